// ===== rtl/assert_macros.svh =====
// Assertion macros used by the compositor top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// ===== rtl/afc_pkg.sv =====
// Package: constants, command and status types for the frame compositor.
`timescale 1ns / 1ps
package afc_pkg;
	localparam int MAX_CANVAS_WIDTH  = 64;
	localparam int MAX_CANVAS_HEIGHT = 32;
	localparam int XW = $clog2(MAX_CANVAS_WIDTH);
	localparam int YW = $clog2(MAX_CANVAS_HEIGHT);
	localparam int AW = XW + YW;

	localparam logic [1:0] OP_HEADER = 2'd0;
	localparam logic [1:0] OP_PIXEL  = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic       load;     // latch input item
		logic       header;   // apply header decision
		logic       pix_rd;   // read canvas for pixel
		logic       pix_wr;   // write blended pixel, advance raster
		logic       rd_rd;    // read canvas for read item
		logic       sweep_start_key;
		logic       sweep_start_disp;
		logic       sweep_step;
		logic       result;   // present result
	} afc_cmd_t;

	typedef struct packed {
		logic       sweep_done;
		logic [1:0] op;
	} afc_stat_t;
endpackage

// ===== rtl/afc_ctrl.sv =====
// Controller state machine for the frame compositor.
`timescale 1ns / 1ps
module afc_ctrl import afc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  afc_stat_t stat,
	output afc_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_WR    = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (stat.op)
					OP_HEADER: begin
						cmd.header = 1'b1;
						cmd.sweep_start_key = 1'b1;
						state_d = S_SWEEP;
					end
					OP_PIXEL: begin
						cmd.pix_rd = 1'b1;
						state_d = S_WR;
					end
					OP_END: begin
						cmd.sweep_start_disp = 1'b1;
						state_d = S_SWEEP;
					end
					default: begin
						cmd.rd_rd = 1'b1;
						state_d = S_RD;
					end
				endcase
			end
			S_RD: state_d = S_OUT;
			S_WR: begin
				cmd.pix_wr = 1'b1;
				state_d = S_OUT;
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_done) state_d = S_OUT;
			end
			S_OUT: begin
				cmd.result = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== rtl/afc_datapath.sv =====
// Datapath: canvas memory, frame state, blend arithmetic and clear sweep.
`timescale 1ns / 1ps
module afc_datapath import afc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  afc_cmd_t    cmd,
	output afc_stat_t   stat,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic [1:0]  op,
	input  logic [7:0]  frame_left,
	input  logic [7:0]  frame_top,
	input  logic [8:0]  frame_width,
	input  logic [8:0]  frame_height,
	input  logic        first_frame,
	input  logic        frame_has_alpha,
	input  logic        blend_requested,
	input  logic        dispose_background,
	input  logic [7:0]  pixel_red,
	input  logic [7:0]  pixel_green,
	input  logic [31:0] pixel_rgb_alpha,
	output logic        key_frame,
	output logic [7:0]  canvas_red,
	output logic [7:0]  canvas_green,
	output logic [7:0]  canvas_blue
);
	localparam int DEPTH = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;

	logic [6:0]  cw_q;
	logic [5:0]  ch_q;
	logic [1:0]  op_q;
	logic [7:0]  in_l_q, in_t_q, sr_q, sg_q, sb_q, a_q;
	logic [8:0]  in_w_q, in_h_q;
	logic        in_first_q, in_alpha_q, in_blend_q, in_disp_q;

	logic [7:0]  hl_q, ht_q;
	logic [8:0]  hw_q, hh_q;
	logic        hd_q, blend_q, done_q, pdisp_q, pfull_q, pkey_q;
	logic [7:0]  col_q, row_q;
	logic        key_q;

	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_q;
	logic        hit_q;
	logic [AW-1:0] paddr_q;

	// sweep
	logic [8:0]  sx_q, sy_q, sx_end_q, sy_end_q, sx0_q;
	logic        sweep_on_q;

	logic [8:0] cw_u, ch_u;
	assign cw_u = (cw_q > 7'(MAX_CANVAS_WIDTH)) ? 9'(MAX_CANVAS_WIDTH) : 9'(cw_q);
	assign ch_u = (ch_q > 6'(MAX_CANVAS_HEIGHT)) ? 9'(MAX_CANVAS_HEIGHT) : 9'(ch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= 7'd64;
			ch_q <= 6'd32;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_WIDTH) cw_q <= cfg_data;
			else ch_q <= cfg_data[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; in_l_q <= frame_left; in_t_q <= frame_top;
			in_w_q <= frame_width; in_h_q <= frame_height;
			in_first_q <= first_frame; in_alpha_q <= frame_has_alpha;
			in_blend_q <= blend_requested; in_disp_q <= dispose_background;
			sr_q <= pixel_red; sg_q <= pixel_green;
			sb_q <= pixel_rgb_alpha[7:0]; a_q <= pixel_rgb_alpha[15:8];
		end
	end

	// header decision
	logic full, key_d;
	assign full = (in_w_q == cw_u) && (in_h_q == ch_u);
	assign key_d = in_first_q || ((!in_alpha_q || !in_blend_q) && full) ||
		(pdisp_q && (pfull_q || pkey_q));

	// pixel position
	logic [8:0] cx, cy;
	logic       pix_hit;
	assign cx = 9'(hl_q) + 9'(col_q);
	assign cy = 9'(ht_q) + 9'(row_q);
	assign pix_hit = !done_q && (cx < cw_u) && (cy < ch_u);

	logic [8:0] rx, ry;
	logic       rinside;
	assign rx = 9'(in_l_q);
	assign ry = 9'(in_t_q);
	assign rinside = (rx < cw_u) && (ry < ch_u);

	logic [8:0] col1, row1;
	assign col1 = 9'(col_q) + 9'd1;
	assign row1 = 9'(row_q) + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q <= '0; ht_q <= '0; hw_q <= '0; hh_q <= '0; hd_q <= 1'b0;
			blend_q <= 1'b0; done_q <= 1'b1; pdisp_q <= 1'b0; pfull_q <= 1'b0;
			pkey_q <= 1'b0; col_q <= '0; row_q <= '0; key_q <= 1'b0; hit_q <= 1'b0;
		end else begin
			if (cmd.load) key_q <= 1'b0;
			if (cmd.header) begin
				hl_q <= in_l_q; ht_q <= in_t_q; hw_q <= in_w_q; hh_q <= in_h_q;
				hd_q <= in_disp_q;
				blend_q <= !in_first_q && in_blend_q && !key_d;
				col_q <= '0; row_q <= '0;
				done_q <= (in_w_q == 9'd0) || (in_h_q == 9'd0);
				pdisp_q <= in_disp_q; pfull_q <= full; pkey_q <= key_d;
				key_q <= key_d;
			end
			if (cmd.pix_rd) hit_q <= pix_hit;
			if (cmd.rd_rd) hit_q <= rinside;
			// 9-bit widths and heights run to 511; the walk compare clamps them to 256
			if (cmd.pix_wr && !done_q) begin
				if (col1 >= ((hw_q > 9'd256) ? 9'd256 : hw_q)) begin
					col_q <= '0;
					if (row1 >= ((hh_q > 9'd256) ? 9'd256 : hh_q)) begin
						row_q <= '0;
						done_q <= 1'b1;
					end else row_q <= row1[7:0];
				end else col_q <= col1[7:0];
			end
		end
	end

	// blend: one channel product pair per channel, combinational result
	function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
		input logic [7:0] a);
		logic [16:0] t;
		logic [17:0] q;
		t = 17'({8'd0, s} * {8'd0, a}) + 17'({8'd0, d} * {8'd0, 8'd255 - a});
		// t/255 for t < 65026: (t + 1 + (t >> 8)) >> 8
		q = 18'(t) + 18'd1 + 18'(t >> 8);
		mix = q[15:8];
	endfunction

	logic [23:0] wdata;
	logic        do_wr;
	always_comb begin
		do_wr = 1'b0;
		wdata = {sr_q, sg_q, sb_q};
		if (hit_q && !done_q) begin
			if (!blend_q || a_q == 8'd255) do_wr = 1'b1;
			else if (a_q != 8'd0) begin
				do_wr = 1'b1;
				wdata = {mix(sr_q, rdata_q[23:16], a_q), mix(sg_q, rdata_q[15:8], a_q),
					mix(sb_q, rdata_q[7:0], a_q)};
			end
		end
	end

	// sweep control
	logic [AW-1:0] saddr;
	assign saddr = {sy_q[YW-1:0], sx_q[XW-1:0]};
	logic last_x, last_y;
	assign last_x = (sx_q + 9'd1 >= sx_end_q);
	assign last_y = (sy_q + 9'd1 >= sy_end_q);
	logic sweep_fin;
	assign sweep_fin = !sweep_on_q || (last_x && last_y);
	assign stat = '{sweep_done: sweep_fin, op: op_q};

	logic [9:0] ex, ey;
	assign ex = 10'(hl_q) + 10'(hw_q);
	assign ey = 10'(ht_q) + 10'(hh_q);

	// a key frame clears the whole store, not just the canvas in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_on_q <= 1'b0;
			sx_q <= '0; sy_q <= '0; sx0_q <= '0;
			sx_end_q <= '0; sy_end_q <= '0;
		end else if (cmd.sweep_start_key) begin
			sweep_on_q <= key_d;
			sx_q <= '0; sy_q <= '0; sx0_q <= '0;
			sx_end_q <= 9'(MAX_CANVAS_WIDTH); sy_end_q <= 9'(MAX_CANVAS_HEIGHT);
		end else if (cmd.sweep_start_disp) begin
			sweep_on_q <= hd_q && (9'(hl_q) < cw_u) && (9'(ht_q) < ch_u)
				&& hw_q != 9'd0 && hh_q != 9'd0;
			sx_q <= 9'(hl_q); sy_q <= 9'(ht_q); sx0_q <= 9'(hl_q);
			sx_end_q <= (ex < 10'(cw_u)) ? ex[8:0] : cw_u;
			sy_end_q <= (ey < 10'(ch_u)) ? ey[8:0] : ch_u;
		end else if (cmd.sweep_step && sweep_on_q) begin
			if (last_x) begin
				sx_q <= sx0_q;
				if (last_y) sweep_on_q <= 1'b0;
				else sy_q <= sy_q + 9'd1;
			end else sx_q <= sx_q + 9'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_rd) paddr_q <= {cy[YW-1:0], cx[XW-1:0]};
		if (cmd.pix_rd) rdata_q <= mem[{cy[YW-1:0], cx[XW-1:0]}];
		else if (cmd.rd_rd) rdata_q <= mem[{ry[YW-1:0], rx[XW-1:0]}];
		if (cmd.sweep_step && sweep_on_q) mem[saddr] <= '0;
		else if (cmd.pix_wr && do_wr) mem[paddr_q] <= wdata;
	end

	logic is_read;
	assign is_read = cmd.result && (op_q == OP_READ) && hit_q;
	assign key_frame    = cmd.result && (op_q == OP_HEADER) && key_q;
	assign canvas_red   = is_read ? rdata_q[23:16] : 8'd0;
	assign canvas_green = is_read ? rdata_q[15:8]  : 8'd0;
	assign canvas_blue  = is_read ? rdata_q[7:0]   : 8'd0;
endmodule

// ===== rtl/animation_frame_compositor_core.sv =====
// Top level of the animation frame compositor.
`timescale 1ns / 1ps
// Items are taken when start is high and busy low; each item gives one result,
// shown for one cycle with done high, and the receiver cannot stall it. Reads
// and pixels pass through decode with canvas read, then blend and write-back
// or data wait, then the result; busy drops in the cycle after the result, so
// a new item is taken only once the last one is through. A header goes through
// decode, sweep and result; a key frame sweeps the whole canvas store to zero.
// A frame end with dispose sweeps the clipped rectangle to zero.
// Configuration writes are always ready and take effect at once.
`include "assert_macros.svh"
module animation_frame_compositor_core import afc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic [1:0]  op,
	input  logic [7:0]  frame_left,
	input  logic [7:0]  frame_top,
	input  logic [8:0]  frame_width,
	input  logic [8:0]  frame_height,
	input  logic        first_frame,
	input  logic        frame_has_alpha,
	input  logic        blend_requested,
	input  logic        dispose_background,
	input  logic [7:0]  pixel_red,
	input  logic [7:0]  pixel_green,
	input  logic [31:0] pixel_rgb_alpha,
	output logic        key_frame,
	output logic [7:0]  canvas_red,
	output logic [7:0]  canvas_green,
	output logic [7:0]  canvas_blue
);
	afc_cmd_t  cmd;
	afc_stat_t stat;

	assign cfg_ready = 1'b1;
	assign done = cmd.result;

	afc_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .stat, .cmd);

	afc_datapath u_dp (.clk, .arst_n, .cmd, .stat, .cfg_valid, .cfg_index, .cfg_data,
		.op, .frame_left, .frame_top, .frame_width, .frame_height, .first_frame,
		.frame_has_alpha, .blend_requested, .dispose_background, .pixel_red,
		.pixel_green, .pixel_rgb_alpha, .key_frame, .canvas_red, .canvas_green,
		.canvas_blue);

	// an accepted item raises busy
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	// the result cycle ends the item
	`ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy)
	// key mark only on a result
	`ASSERT_IMPL(a_key_done, clk, arst_n, key_frame, done)
endmodule

// ===== verif/testbench.sv =====
// Testbench for the animation frame compositor: directed and random frames, checked by a predictor.
`timescale 1ns / 1ps
module testbench import afc_pkg::*; ();

	// One input item, all fields as the ports carry them.
	typedef struct {
		logic [1:0]  op;
		logic [7:0]  left;
		logic [7:0]  top;
		logic [8:0]  width;
		logic [8:0]  height;
		logic        first;
		logic        alpha_flag;
		logic        blend;
		logic        dispose;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [31:0] blue_alpha;
	} frame_item_t;

	// One result: key decision and canvas colour.
	typedef struct {
		logic       key;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} canvas_reply_t;

	localparam int STORE_DEPTH = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
	localparam int CYCLE_LIMIT = 10_000_000;
	// Longest single item: a full clear sweep plus pipeline.
	localparam int SETTLE_CYCLES = 2 * STORE_DEPTH + 16;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [6:0]  cfg_data;
	logic [1:0]  op;
	logic [7:0]  frame_left;
	logic [7:0]  frame_top;
	logic [8:0]  frame_width;
	logic [8:0]  frame_height;
	logic        first_frame;
	logic        frame_has_alpha;
	logic        blend_requested;
	logic        dispose_background;
	logic [7:0]  pixel_red;
	logic [7:0]  pixel_green;
	logic [31:0] pixel_rgb_alpha;
	logic        key_frame;
	logic [7:0]  canvas_red;
	logic [7:0]  canvas_green;
	logic [7:0]  canvas_blue;

	animation_frame_compositor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.op(op),
		.frame_left(frame_left),
		.frame_top(frame_top),
		.frame_width(frame_width),
		.frame_height(frame_height),
		.first_frame(first_frame),
		.frame_has_alpha(frame_has_alpha),
		.blend_requested(blend_requested),
		.dispose_background(dispose_background),
		.pixel_red(pixel_red),
		.pixel_green(pixel_green),
		.pixel_rgb_alpha(pixel_rgb_alpha),
		.key_frame(key_frame),
		.canvas_red(canvas_red),
		.canvas_green(canvas_green),
		.canvas_blue(canvas_blue)
	);

	// Shadow copy of the block's state.
	logic [23:0] canvas_mirror [0:STORE_DEPTH-1];
	int          reg_width;
	int          reg_height;
	int          hdr_left, hdr_top, hdr_width, hdr_height;
	logic        hdr_dispose;
	logic        blending;
	int          raster_col, raster_row;
	logic        frame_done;
	logic        prev_dispose, prev_full, prev_key;

	canvas_reply_t canvas_replies [$];
	int            error_count;
	longint        cycle_count;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int used_width();
		return (reg_width > MAX_CANVAS_WIDTH) ? MAX_CANVAS_WIDTH : reg_width;
	endfunction

	function automatic int used_height();
		return (reg_height > MAX_CANVAS_HEIGHT) ? MAX_CANVAS_HEIGHT : reg_height;
	endfunction

	function automatic int walk_len(int v);
		return (v > 256) ? 256 : v;
	endfunction

	function automatic logic [7:0] alpha_mix(int s, int d, int a);
		return 8'((s * a + d * (255 - a)) / 255);
	endfunction

	function automatic void clear_mirror();
		for (int i = 0; i < STORE_DEPTH; i++) canvas_mirror[i] = '0;
	endfunction

	// Advance the shadow state by one item and return the result it should give.
	function automatic canvas_reply_t composite_item(frame_item_t it);
		canvas_reply_t rep;
		int cw, ch, cx, cy, idx, a;
		logic full, key;
		logic [23:0] d;
		rep = '{1'b0, 8'd0, 8'd0, 8'd0};
		cw = used_width();
		ch = used_height();
		case (it.op)
			OP_HEADER: begin
				full = (int'(it.width) == cw) && (int'(it.height) == ch);
				if (it.first) key = 1'b1;
				else if ((!it.alpha_flag || !it.blend) && full) key = 1'b1;
				else key = prev_dispose && (prev_full || prev_key);
				if (key) clear_mirror();
				hdr_left = int'(it.left);
				hdr_top = int'(it.top);
				hdr_width = int'(it.width);
				hdr_height = int'(it.height);
				hdr_dispose = it.dispose;
				blending = !it.first && it.blend && !key;
				raster_col = 0;
				raster_row = 0;
				frame_done = (it.width == 0) || (it.height == 0);
				prev_dispose = it.dispose;
				prev_full = full;
				prev_key = key;
				rep.key = key;
			end
			OP_PIXEL: begin
				if (!frame_done) begin
					cx = hdr_left + raster_col;
					cy = hdr_top + raster_row;
					if (cx < cw && cy < ch) begin
						idx = cy * MAX_CANVAS_WIDTH + cx;
						a = int'(it.blue_alpha[15:8]);
						d = canvas_mirror[idx];
						if (!blending || a == 255)
							canvas_mirror[idx] = {it.red, it.green, it.blue_alpha[7:0]};
						else if (a != 0)
							canvas_mirror[idx] = {alpha_mix(int'(it.red), int'(d[23:16]), a),
								alpha_mix(int'(it.green), int'(d[15:8]), a),
								alpha_mix(int'(it.blue_alpha[7:0]), int'(d[7:0]), a)};
					end
					if (raster_col + 1 >= walk_len(hdr_width)) begin
						raster_col = 0;
						if (raster_row + 1 >= walk_len(hdr_height)) begin
							raster_row = 0;
							frame_done = 1'b1;
						end else begin
							raster_row = raster_row + 1;
						end
					end else begin
						raster_col = raster_col + 1;
					end
				end
			end
			OP_END: begin
				if (hdr_dispose) begin
					for (int y = 0; y < hdr_height && hdr_top + y < ch; y++)
						for (int x = 0; x < hdr_width && hdr_left + x < cw; x++)
							canvas_mirror[(hdr_top + y) * MAX_CANVAS_WIDTH + hdr_left + x] = '0;
				end
			end
			default: begin
				if (it.left < cw && it.top < ch) begin
					d = canvas_mirror[it.top * MAX_CANVAS_WIDTH + it.left];
					rep.red = d[23:16];
					rep.green = d[15:8];
					rep.blue = d[7:0];
				end
			end
		endcase
		return rep;
	endfunction

	// Every field random; callers override what the op uses.
	function automatic frame_item_t random_item(logic [1:0] kind);
		frame_item_t it;
		it.op = kind;
		it.left = 8'($urandom);
		it.top = 8'($urandom);
		it.width = 9'($urandom);
		it.height = 9'($urandom);
		it.first = 1'($urandom);
		it.alpha_flag = 1'($urandom);
		it.blend = 1'($urandom);
		it.dispose = 1'($urandom);
		it.red = 8'($urandom);
		it.green = 8'($urandom);
		it.blue_alpha = $urandom;
		return it;
	endfunction

	// Drive one item, wait for it to be taken, queue its expected result, then idle for a random gap, often none.
	task automatic issue_item(frame_item_t it);
		int gap;
		start <= 1'b1;
		op <= it.op;
		frame_left <= it.left;
		frame_top <= it.top;
		frame_width <= it.width;
		frame_height <= it.height;
		first_frame <= it.first;
		frame_has_alpha <= it.alpha_flag;
		blend_requested <= it.blend;
		dispose_background <= it.dispose;
		pixel_red <= it.red;
		pixel_green <= it.green;
		pixel_rgb_alpha <= it.blue_alpha;
		@(posedge clk);
		while (busy) @(posedge clk);
		canvas_replies.push_back(composite_item(it));
		// Bursts without gaps somewhat more than a third of the time.
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (canvas_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_WIDTH) reg_width = int'(value);
		else reg_height = int'(value);
	endtask

	task automatic send_header(int l, int t, int w, int h, logic fst, logic alp,
			logic bln, logic dsp);
		frame_item_t it;
		it = random_item(OP_HEADER);
		it.left = 8'(l);
		it.top = 8'(t);
		it.width = 9'(w);
		it.height = 9'(h);
		it.first = fst;
		it.alpha_flag = alp;
		it.blend = bln;
		it.dispose = dsp;
		issue_item(it);
	endtask

	task automatic send_pixel(int alpha);
		frame_item_t it;
		it = random_item(OP_PIXEL);
		if (alpha >= 0) it.blue_alpha[15:8] = 8'(alpha);
		issue_item(it);
	endtask

	task automatic send_read(int col, int row);
		frame_item_t it;
		it = random_item(OP_READ);
		it.left = 8'(col);
		it.top = 8'(row);
		issue_item(it);
	endtask

	task automatic send_end();
		issue_item(random_item(OP_END));
	endtask

	// Stray pixel before any header, then a first frame with extreme colours.
	task automatic test_first_frame();
		frame_item_t it;
		send_pixel(-1);
		send_header(0, 0, 2, 2, 1'b1, 1'b1, 1'b1, 1'b0);
		it = random_item(OP_PIXEL);
		it.red = 8'hFF; it.green = 8'hFF; it.blue_alpha = 32'hFFFF_FFFF;
		issue_item(it);
		it.red = 8'h00; it.green = 8'h00; it.blue_alpha = 32'h0000_0000;
		issue_item(it);
		send_pixel(-1);
		send_pixel(-1);
		send_pixel(-1);          // past the last pixel: dropped
		send_read(0, 0);
		send_read(1, 1);
		send_read(255, 255);     // outside canvas reads zero
	endtask

	// Blending frame: transparent, opaque and partial alpha.
	task automatic test_blend();
		send_header(0, 0, 3, 1, 1'b0, 1'b1, 1'b1, 1'b1);
		send_pixel(0);
		send_pixel(255);
		send_pixel(128);
		send_read(0, 0);
		send_read(1, 0);
		send_read(2, 0);
		send_end();              // dispose to background
		send_end();              // repeated end clears again
		send_read(2, 0);
	endtask

	// Oversized and empty frames, and a key frame from a full-size dispose.
	task automatic test_sizes();
		send_header(62, 30, 511, 256, 1'b0, 1'b0, 1'b0, 1'b1);
		send_pixel(-1);
		send_pixel(-1);
		send_pixel(-1);          // clipped past the right edge
		send_header(255, 255, 0, 5, 1'b0, 1'b1, 1'b1, 1'b0);
		send_pixel(-1);
		send_header(0, 0, 64, 32, 1'b0, 1'b0, 1'b1, 1'b1);
		send_header(1, 1, 2, 2, 1'b0, 1'b1, 1'b1, 1'b0);
		send_read(63, 31);
	endtask

	// Random animation: headers, pixel runs, reads and frame ends.
	task automatic play_frames(int count);
		int cw, ch, sel, w, h, l, t, npx;
		for (int f = 0; f < count; f++) begin
			cw = used_width();
			ch = used_height();
			sel = $urandom_range(0, 9);
			l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cw);
			t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, ch);
			if (sel < 2) begin
				w = cw; h = ch; l = 0; t = 0;
			end else if (sel == 2) begin
				w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
				h = (w == 0) ? $urandom_range(0, 4) : 0;
			end else if (sel == 3) begin
				w = $urandom_range(256, 511);
				h = $urandom_range(1, 2);
			end else begin
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 5);
			end
			send_header(l, t, w, h, $urandom_range(0, 15) == 0, 1'($urandom), 1'($urandom),
				1'($urandom));
			npx = walk_len(w) * walk_len(h);
			if (npx > 30) npx = 30;
			npx = npx + $urandom_range(0, 1);
			for (int p = 0; p < npx; p++) begin
				case ($urandom_range(0, 3))
					0: send_pixel(0);
					1: send_pixel(255);
					default: send_pixel(-1);
				endcase
			end
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 4) == 0) send_read($urandom, $urandom);
				else send_read($urandom_range(0, cw - 1), $urandom_range(0, ch - 1));
			end
			if ($urandom_range(0, 9) < 7) send_end();
		end
	endtask

	// Canvas settings, extremes and out-of-range values; each starts with a
	// first frame so every used entry is written before it is read.
	task automatic test_canvas_settings();
		int widths [6] = '{1, 64, 127, 7, 33, 64};
		int heights [6] = '{1, 32, 63, 5, 17, 1};
		for (int s = 0; s < 6; s++) begin
			wait_idle();
			write_reg(CFG_WIDTH, 7'(widths[s]));
			write_reg(CFG_HEIGHT, 7'(heights[s]));
			send_header(0, 0, 1, 1, 1'b1, 1'b0, 1'b0, 1'b0);
			play_frames(5);
		end
	endtask

	// Results arrive in order, one per item.
	always @(posedge clk) begin
		canvas_reply_t exp;
		if (arst_n && done) begin
			if (canvas_replies.size() == 0) begin
				$display("%0t: unexpected result key=%0b rgb=%02h%02h%02h", $time,
					key_frame, canvas_red, canvas_green, canvas_blue);
				error_count++;
			end else begin
				exp = canvas_replies.pop_front();
				if (key_frame !== exp.key) begin
					$display("%0t: key_frame expected %0b actual %0b", $time, exp.key, key_frame);
					error_count++;
				end
				if (canvas_red !== exp.red) begin
					$display("%0t: canvas_red expected %02h actual %02h", $time,
						exp.red, canvas_red);
					error_count++;
				end
				if (canvas_green !== exp.green) begin
					$display("%0t: canvas_green expected %02h actual %02h", $time,
						exp.green, canvas_green);
					error_count++;
				end
				if (canvas_blue !== exp.blue) begin
					$display("%0t: canvas_blue expected %02h actual %02h", $time,
						exp.blue, canvas_blue);
					error_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, canvas_replies.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		reg_width = 64;
		reg_height = 32;
		hdr_left = 0; hdr_top = 0; hdr_width = 0; hdr_height = 0;
		hdr_dispose = 1'b0;
		blending = 1'b0;
		raster_col = 0;
		raster_row = 0;
		frame_done = 1'b1;
		prev_dispose = 1'b0;
		prev_full = 1'b0;
		prev_key = 1'b0;
		clear_mirror();
		arst_n <= 1'b0;
		start <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= 1'b0;
		cfg_data <= '0;
		op <= OP_HEADER;
		frame_left <= '0;
		frame_top <= '0;
		frame_width <= '0;
		frame_height <= '0;
		first_frame <= 1'b0;
		frame_has_alpha <= 1'b0;
		blend_requested <= 1'b0;
		dispose_background <= 1'b0;
		pixel_red <= '0;
		pixel_green <= '0;
		pixel_rgb_alpha <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_frame();
		test_blend();
		test_sizes();
		test_canvas_settings();

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
